// ===== rtl/lgge_pkg.sv =====
// shared constants, state type and cell rule for the life grid generation engine
package lgge_pkg;

	// port field widths
	localparam int OP_W  = 2;
	localparam int ROW_W = 5;
	localparam int COL_W = 6;

	// default grid size
	localparam int GRID_ROWS_DEF = 32;
	localparam int GRID_COLS_DEF = 64;

	// command codes
	localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ    = 2'd2;

	// neighbour counts of the rule
	localparam logic [3:0] SURVIVE_MIN = 4'd2;
	localparam logic [3:0] BIRTH_COUNT = 4'd3;

	// control states of the top level
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADV,
		ST_RESP
	} state_t;

	// next value of the center cell of a 3x3 window, columns given as {top, mid, bottom}
	function automatic logic life_next(logic [2:0] lft, logic [2:0] mid, logic [2:0] rgt);
		logic [3:0] n;
		n = 4'(lft[0]) + 4'(lft[1]) + 4'(lft[2]) + 4'(rgt[0]) + 4'(rgt[1]) + 4'(rgt[2])
			+ 4'(mid[0]) + 4'(mid[2]);
		return mid[1] ? (n == SURVIVE_MIN || n == BIRTH_COUNT) : (n == BIRTH_COUNT);
	endfunction

endpackage

// ===== rtl/lgge_ram.sv =====
// generic simple dual port ram with registered read
module lgge_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/lgge_sweep.sv =====
// raster sweep of one generation: source reads, two line buffers, 3x3 window, rule, write back
module lgge_sweep #(
	parameter int GRID_ROWS = lgge_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLS = lgge_pkg::GRID_COLS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          start,
	output logic                                          done,
	output logic                                          rd_en,
	output logic [$clog2(GRID_ROWS)+$clog2(GRID_COLS)-1:0] rd_addr,
	input  logic                                          rd_data,
	output logic                                          wr_en,
	output logic [$clog2(GRID_ROWS)+$clog2(GRID_COLS)-1:0] wr_addr,
	output logic                                          wr_data
);

	localparam int RW  = $clog2(GRID_ROWS);
	localparam int CW  = $clog2(GRID_COLS);
	localparam int RCW = $clog2(GRID_ROWS + 1);
	localparam int CCW = $clog2(GRID_COLS + 1);
	localparam logic [RCW-1:0] ROW_END = RCW'(GRID_ROWS);
	localparam logic [CCW-1:0] COL_END = CCW'(GRID_COLS);

	// scan position, one extra zero row and one extra zero column at the ends
	logic           run_q;
	logic [RCW-1:0] r_q;
	logic [CCW-1:0] c_q;
	logic           scan_last;

	// stage 1: source data back from the ram
	logic           vld_s1;
	logic           real_s1;
	logic           last_s1;
	logic [RCW-1:0] r_s1;
	logic [CCW-1:0] c_s1;
	logic           x_s1;
	logic [2:0]     trip_s1;
	logic           col_in_s1;

	// line buffers and window
	logic [GRID_COLS-1:0] lb1_q;
	logic [GRID_COLS-1:0] lb2_q;
	logic [2:0]           w0_q;
	logic [2:0]           w1_q;
	logic [2:0]           w2_q;

	// stage 2: write back
	logic          wr_vld_s2;
	logic          last_s2;
	logic [RW-1:0] wr_row_s2;
	logic [CW-1:0] wr_col_s2;

	assign scan_last = (r_q == ROW_END) && (c_q == COL_END);
	assign rd_en     = run_q && (r_q < ROW_END) && (c_q < COL_END);
	assign rd_addr   = {RW'(r_q), CW'(c_q)};

	// scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			r_q   <= '0;
			c_q   <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			r_q   <= '0;
			c_q   <= '0;
		end else if (run_q) begin
			if (c_q == COL_END) begin
				c_q <= '0;
				if (r_q == ROW_END) begin
					run_q <= 1'b0;
				end else begin
					r_q <= r_q + RCW'(1);
				end
			end else begin
				c_q <= c_q + CCW'(1);
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			vld_s1  <= run_q;
			last_s1 <= run_q && scan_last;
		end
	end

	// stage 1 position
	always_ff @(posedge clk) begin
		r_s1    <= r_q;
		c_s1    <= c_q;
		real_s1 <= rd_en;
	end

	// cells outside the grid read as dead
	assign x_s1      = real_s1 && rd_data;
	assign col_in_s1 = (c_s1 != COL_END);
	assign trip_s1   = col_in_s1 ? {lb2_q[GRID_COLS-1], lb1_q[GRID_COLS-1], x_s1} : 3'b000;

	// line buffers, cleared at the start of a sweep so rows above the grid are dead
	always_ff @(posedge clk) begin
		if (start) begin
			lb1_q <= '0;
			lb2_q <= '0;
		end else if (vld_s1 && col_in_s1) begin
			lb1_q <= {lb1_q[GRID_COLS-2:0], x_s1};
			lb2_q <= {lb2_q[GRID_COLS-2:0], lb1_q[GRID_COLS-1]};
		end
	end

	// window of three columns, left columns dead at the start of a row
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			if (c_s1 == '0) begin
				w0_q <= 3'b000;
				w1_q <= 3'b000;
			end else begin
				w0_q <= w1_q;
				w1_q <= w2_q;
			end
			w2_q <= trip_s1;
		end
	end

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_s2 <= 1'b0;
			last_s2   <= 1'b0;
		end else begin
			wr_vld_s2 <= vld_s1 && (r_s1 != '0) && (c_s1 != '0);
			last_s2   <= last_s1;
		end
	end

	// window center sits one row and one column behind the source word
	always_ff @(posedge clk) begin
		wr_row_s2 <= RW'(r_s1 - RCW'(1));
		wr_col_s2 <= CW'(c_s1 - CCW'(1));
	end

	assign wr_en   = wr_vld_s2;
	assign wr_addr = {wr_row_s2, wr_col_s2};
	assign wr_data = lgge_pkg::life_next(w0_q, w1_q, w2_q);
	assign done    = last_s2;

endmodule

// ===== rtl/life_grid_generation_engine_unit.sv =====
// top level of the life grid generation engine: command decode, buffers, response register
//
// Conway life (B3/S23) engine over a GRID_ROWS x GRID_COLS grid held in two one-bit rams.
// Command channel (cmd_valid/cmd_ready) takes one word: op, row, col, cell_in.
//   write: stores cell_in in the current buffer, cells outside the grid are ignored.
//   read: returns the current cell on cell_out with is_read set, 0 outside the grid.
//   advance: computes the next generation into the other buffer, then swaps buffers.
// Response channel (rsp_valid/rsp_ready) gives exactly one word per command.
// Write and read pass through the RESP state to the response register; advance sweeps
//   the grid plus one zero row and one zero column in raster order, with one source ram
//   read per cycle inside the grid feeding two line buffers and a 3x3 window.
// One command is in work at a time; the next one is taken as soon as the previous
//   response sits in the output register, even while the receiver stalls it.
// A stalled response holds its word; a finished command waits for the register to free.
// Reset: both buffers are cleared by a pass over all GRID_ROWS * 2**clog2(GRID_COLS) addresses
//   (2048 at 32x64), with cmd_ready low; grid_a is current afterwards.
module life_grid_generation_engine_unit #(
	parameter int GRID_ROWS = lgge_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLS = lgge_pkg::GRID_COLS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  logic [lgge_pkg::OP_W-1:0]  op,
	input  logic [lgge_pkg::ROW_W-1:0] row,
	input  logic [lgge_pkg::COL_W-1:0] col,
	input  logic                       cell_in,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output logic                       cell_out,
	output logic                       is_read
);

	localparam int RW    = $clog2(GRID_ROWS);
	localparam int CW    = $clog2(GRID_COLS);
	localparam int AW    = RW + CW;
	localparam int DEPTH = GRID_ROWS * (2 ** CW);

	lgge_pkg::state_t state_q;
	lgge_pkg::state_t state_d;

	logic [AW-1:0]             clr_cnt_q;
	logic                      cur_b_q;
	logic [lgge_pkg::OP_W-1:0] op_q;
	logic                      in_grid_q;
	logic                      rsp_valid_q;
	logic                      cell_out_q;
	logic                      is_read_q;

	logic          accept;
	logic          in_grid;
	logic [AW-1:0] cell_addr;
	logic          wr_acc;
	logic          rd_acc;
	logic          clearing;
	logic          slot_free;
	logic          rsp_load;

	logic          sw_start;
	logic          sw_done;
	logic          sw_rd_en;
	logic [AW-1:0] sw_rd_addr;
	logic          sw_wr_en;
	logic [AW-1:0] sw_wr_addr;
	logic          sw_wr_data;

	logic          a_we;
	logic          b_we;
	logic          a_re;
	logic          b_re;
	logic [AW-1:0] wr_addr;
	logic          wr_data;
	logic [AW-1:0] rd_addr;
	logic          a_rdata;
	logic          b_rdata;
	logic          cur_rdata;

	// command decode
	assign accept    = cmd_valid && cmd_ready;
	assign in_grid   = (32'(row) < GRID_ROWS) && (32'(col) < GRID_COLS);
	assign cell_addr = {RW'(row), CW'(col)};
	assign wr_acc    = accept && (op == lgge_pkg::OP_WRITE) && in_grid;
	assign rd_acc    = accept && (op == lgge_pkg::OP_READ);
	assign sw_start  = accept && (op == lgge_pkg::OP_ADVANCE);
	assign clearing  = (state_q == lgge_pkg::ST_CLEAR);
	assign slot_free = !rsp_valid_q || rsp_ready;

	// next state and handshake
	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			lgge_pkg::ST_CLEAR: begin
				if (clr_cnt_q == AW'(DEPTH - 1)) begin
					state_d = lgge_pkg::ST_IDLE;
				end
			end
			lgge_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					state_d = (op == lgge_pkg::OP_ADVANCE) ? lgge_pkg::ST_ADV : lgge_pkg::ST_RESP;
				end
			end
			lgge_pkg::ST_ADV: begin
				if (sw_done) begin
					state_d = lgge_pkg::ST_RESP;
				end
			end
			lgge_pkg::ST_RESP: begin
				if (slot_free) begin
					rsp_load = 1'b1;
					state_d  = lgge_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lgge_pkg::ST_CLEAR;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lgge_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// clearing pass counter and current buffer select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			cur_b_q   <= 1'b0;
		end else begin
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (sw_done) begin
				cur_b_q <= !cur_b_q;
			end
		end
	end

	// command held for the response
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op;
			in_grid_q <= in_grid;
		end
	end

	// ram port steering: sweep writes the next buffer, commands use the current one
	assign a_we    = clearing || (sw_wr_en && cur_b_q) || (wr_acc && !cur_b_q);
	assign b_we    = clearing || (sw_wr_en && !cur_b_q) || (wr_acc && cur_b_q);
	assign wr_addr = clearing ? clr_cnt_q : (sw_wr_en ? sw_wr_addr : cell_addr);
	assign wr_data = clearing ? 1'b0 : (sw_wr_en ? sw_wr_data : cell_in);
	assign rd_addr = sw_rd_en ? sw_rd_addr : cell_addr;
	assign a_re    = !cur_b_q && (sw_rd_en || rd_acc);
	assign b_re    = cur_b_q && (sw_rd_en || rd_acc);
	assign cur_rdata = cur_b_q ? b_rdata : a_rdata;

	lgge_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_grid_a (
		.clk  (clk),
		.we   (a_we),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (a_re),
		.raddr(rd_addr),
		.rdata(a_rdata)
	);

	lgge_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_grid_b (
		.clk  (clk),
		.we   (b_we),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (b_re),
		.raddr(rd_addr),
		.rdata(b_rdata)
	);

	lgge_sweep #(
		.GRID_ROWS(GRID_ROWS),
		.GRID_COLS(GRID_COLS)
	) u_sweep (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sw_start),
		.done   (sw_done),
		.rd_en  (sw_rd_en),
		.rd_addr(sw_rd_addr),
		.rd_data(cur_rdata),
		.wr_en  (sw_wr_en),
		.wr_addr(sw_wr_addr),
		.wr_data(sw_wr_data)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response word
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			is_read_q  <= (op_q == lgge_pkg::OP_READ);
			cell_out_q <= (op_q == lgge_pkg::OP_READ) && in_grid_q && cur_rdata;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign cell_out  = cell_out_q;
	assign is_read   = is_read_q;

	// both buffers are written together only by the clearing pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(a_we && b_we) |-> (state_q == lgge_pkg::ST_CLEAR))
		else $error("both buffers written outside the clearing pass");

	// a sweep finishes only while an advance is in work
	assert property (@(posedge clk) disable iff (!arst_n)
		sw_done |-> (state_q == lgge_pkg::ST_ADV))
		else $error("sweep done outside an advance");

	// buffers swap only at the end of a sweep
	assert property (@(posedge clk) disable iff (!arst_n)
		(cur_b_q != $past(cur_b_q)) |-> $past(sw_done))
		else $error("buffer swap without a finished sweep");

	// a new response word comes only from the response state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == lgge_pkg::ST_RESP))
		else $error("response word loaded outside the response state");

endmodule
